// File: rtl/core/prpe_pkg.sv
`timescale 1ns / 1ps
// Package for the page replacement policy engine.
// Holds register indexes, policy codes and the cell control struct; no dependencies.
package prpe_pkg;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] CFG_POLICY_MODE   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FRAMES_IN_USE = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_AGING_PERIOD  = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_AGE_WIDTH     = 2'd3;

    localparam logic [1:0] MODE_FIFO  = 2'd0;
    localparam logic [1:0] MODE_LRU   = 2'd1;
    localparam logic [1:0] MODE_CLOCK = 2'd2;

    localparam int FIU_W    = 7;
    localparam int PERIOD_W = 16;
    localparam int AGEW_W   = 4;
    localparam int STAMP_W  = 32;
    localparam int COUNT_W  = 32;

    typedef struct packed {
        logic age_shift_all;  // aging tick over all occupied frames
        logic sweep_shift;    // clock hand shifts the selected frame
        logic hit_upd;        // hit update of the selected frame
        logic stamp_last;     // hit also stamps last use
        logic set_top;        // hit also sets the top age bit
        logic fill;           // load the selected frame with the new page
        logic use_lru;        // victim chain compares last use, else arrival
    } t_cell_ctrl;

endpackage

// File: rtl/core/prpe_cell.sv
`timescale 1ns / 1ps
// One frame of the table: tag, dirty, stamps, aging register and a stage of the
// oldest-stamp chain. Depends on prpe_pkg.
module prpe_cell #(
    parameter int IDX       = 0,
    parameter int IDX_W     = 6,
    parameter int OCC_W     = 7,
    parameter int PAGE_BITS = 20,
    parameter int AGE_BITS  = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  prpe_pkg::t_cell_ctrl        i_ctrl,
    input  logic [OCC_W-1:0]            i_occupancy,
    input  logic [IDX_W-1:0]            i_slot,
    input  logic [PAGE_BITS-1:0]        i_page,
    input  logic                        i_wr,
    input  logic [prpe_pkg::STAMP_W-1:0] i_now,
    input  logic [AGE_BITS-1:0]         i_age_mask,
    input  logic [AGE_BITS-1:0]         i_age_top,
    input  logic [prpe_pkg::STAMP_W-1:0] i_prev_stamp,
    input  logic [IDX_W-1:0]            i_prev_idx,
    output logic                        o_match,
    output logic                        o_age_zero,
    output logic                        o_dirty,
    output logic [prpe_pkg::STAMP_W-1:0] o_best_stamp,
    output logic [IDX_W-1:0]            o_best_idx
);

    logic [PAGE_BITS-1:0]         r_tag;
    logic                         r_dirty;
    logic [prpe_pkg::STAMP_W-1:0] r_arrival;
    logic [prpe_pkg::STAMP_W-1:0] r_last;
    logic [AGE_BITS-1:0]          r_age;
    logic [prpe_pkg::STAMP_W-1:0] r_best_stamp;
    logic [IDX_W-1:0]             r_best_idx;

    logic                         occupied;
    logic                         sel;
    logic [prpe_pkg::STAMP_W-1:0] stamp;
    logic [AGE_BITS-1:0]          age_shifted;

    assign occupied    = i_occupancy > OCC_W'(IDX);
    assign sel         = i_slot == IDX_W'(IDX);
    assign stamp       = i_ctrl.use_lru ? r_last : r_arrival;
    assign age_shifted = (r_age & i_age_mask) >> 1;

    assign o_match      = occupied && (r_tag == i_page);
    assign o_age_zero   = (r_age & i_age_mask) == '0;
    assign o_dirty      = r_dirty;
    assign o_best_stamp = r_best_stamp;
    assign o_best_idx   = r_best_idx;

    // Chain stage: keep the older of our stamp and the one from the left.
    always_ff @(posedge i_clk) begin
        if (IDX == 0) begin
            r_best_stamp <= stamp;
            r_best_idx   <= IDX_W'(IDX);
        end else if (occupied && (stamp < i_prev_stamp)) begin
            r_best_stamp <= stamp;
            r_best_idx   <= IDX_W'(IDX);
        end else begin
            r_best_stamp <= i_prev_stamp;
            r_best_idx   <= i_prev_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.fill && sel) begin
            r_tag     <= i_page;
            r_arrival <= i_now;
            r_last    <= i_now;
        end else if (i_ctrl.hit_upd && sel && i_ctrl.stamp_last) begin
            r_last <= i_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dirty <= 1'b0;
            r_age   <= '0;
        end else begin
            if (i_ctrl.age_shift_all && occupied) begin
                r_age <= age_shifted;
            end else if (i_ctrl.sweep_shift && sel) begin
                r_age <= age_shifted;
            end else if (i_ctrl.hit_upd && sel) begin
                if (i_wr) begin
                    r_dirty <= 1'b1;
                end
                if (i_ctrl.set_top) begin
                    r_age <= (r_age & i_age_mask) | i_age_top;
                end
            end else if (i_ctrl.fill && sel) begin
                r_dirty <= i_wr;
                r_age   <= i_age_top;
            end
        end
    end

endmodule

// File: rtl/core/page_replacement_policy_engine_top.sv
`timescale 1ns / 1ps
// Top level of the page replacement policy engine: configuration, sequencer,
// counters and the row of frame cells. Depends on prpe_pkg and prpe_cell.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+----------------------------------------------
//  in       | i_in_valid / o_in_ready   | i_page_number, i_is_write
//  out      | o_out_valid / i_out_ready | o_hit, o_frame_slot, o_evicted_dirty,
//           |                           | o_fault_total, o_writeback_total, o_dirty_resident
//  cfg      | i_cfg_we                  | i_cfg_addr, i_cfg_wdata
//
// One transaction at a time. A hit passes through tick and lookup; a fill adds a
// write. A FIFO or LRU eviction adds a scan while the oldest stamp ripples down
// the cell row. A clock eviction adds a sweep that steps the hand to a zero age.
// Reset is synchronous; all frames come up empty. A result held in the output
// register stalls the next completion, not acceptance.
module page_replacement_policy_engine_top #(
    parameter int FRAMES       = 64,
    parameter int PAGE_BITS    = 20,
    parameter int MAX_AGE_BITS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [prpe_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [prpe_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [PAGE_BITS-1:0]            i_page_number,
    input  logic                            i_is_write,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_hit,
    output logic [5:0]                      o_frame_slot,
    output logic                            o_evicted_dirty,
    output logic [31:0]                     o_fault_total,
    output logic [31:0]                     o_writeback_total,
    output logic [6:0]                      o_dirty_resident
);

    localparam int IDX_W = $clog2(FRAMES);
    localparam int OCC_W = $clog2(FRAMES + 1);
    localparam int SW    = prpe_pkg::STAMP_W;

    typedef enum logic [2:0] {
        S_IDLE, S_TICK, S_LOOK, S_SCAN, S_SWEEP, S_WRITE, S_DONE
    } t_state;

    t_state r_state;

    logic [1:0]                     r_mode;
    logic [prpe_pkg::FIU_W-1:0]     r_fiu;
    logic [prpe_pkg::PERIOD_W-1:0]  r_period;
    logic [prpe_pkg::AGEW_W-1:0]    r_agew;

    logic [PAGE_BITS-1:0]           r_page;
    logic                           r_wr;
    logic [IDX_W-1:0]               r_slot;
    logic [IDX_W-1:0]               r_hand;
    logic                           r_evict;
    logic                           r_hit;
    logic                           r_evd;
    logic [OCC_W-1:0]               r_occ;
    logic [OCC_W-1:0]               r_scan_cnt;
    logic [SW-1:0]                  r_access;
    logic [prpe_pkg::PERIOD_W-1:0]  r_tick;
    logic [prpe_pkg::COUNT_W-1:0]   r_faults;
    logic [prpe_pkg::COUNT_W-1:0]   r_wbs;
    logic [OCC_W-1:0]               r_dirty_cnt;

    logic                           r_out_valid;
    logic                           r_out_hit;
    logic [5:0]                     r_out_slot;
    logic                           r_out_evd;
    logic [31:0]                    r_out_faults;
    logic [31:0]                    r_out_wbs;
    logic [6:0]                     r_out_dirty;

    prpe_pkg::t_cell_ctrl           cell_ctrl;
    logic [IDX_W-1:0]               slot_bcast;
    logic [FRAMES-1:0]              match_vec;
    logic [FRAMES-1:0]              zero_vec;
    logic [FRAMES-1:0]              dirty_vec;
    logic [SW-1:0]                  best_stamp [FRAMES];
    logic [IDX_W-1:0]               best_idx   [FRAMES];
    logic                           any_match;
    logic [IDX_W-1:0]               match_idx;
    logic [MAX_AGE_BITS-1:0]        age_mask;
    logic [MAX_AGE_BITS-1:0]        age_top;
    logic [5:0]                     age_w;
    logic [OCC_W-1:0]               cap;
    logic [prpe_pkg::PERIOD_W-1:0]  tick_next;
    logic                           tick_fire;

    // Effective age width and capacity after clamping.
    always_comb begin
        if (r_agew == '0) begin
            age_w = 6'd1;
        end else if (32'(r_agew) > 32'(MAX_AGE_BITS)) begin
            age_w = 6'(MAX_AGE_BITS);
        end else begin
            age_w = 6'(r_agew);
        end
        for (int b = 0; b < MAX_AGE_BITS; b++) begin
            age_mask[b] = 6'(b) < age_w;
            age_top[b]  = 6'(b) == (age_w - 6'd1);
        end
        if (r_fiu == '0) begin
            cap = OCC_W'(1);
        end else if (32'(r_fiu) > 32'(FRAMES)) begin
            cap = OCC_W'(FRAMES);
        end else begin
            cap = OCC_W'(r_fiu);
        end
    end

    always_comb begin
        any_match = |match_vec;
        match_idx = '0;
        for (int k = 0; k < FRAMES; k++) begin
            if (match_vec[k]) begin
                match_idx = match_idx | IDX_W'(k);
            end
        end
    end

    assign tick_next = r_tick + 1'b1;
    assign tick_fire = tick_next >= r_period;

    always_comb begin
        cell_ctrl = '0;
        cell_ctrl.use_lru = r_mode == prpe_pkg::MODE_LRU;
        slot_bcast = r_slot;
        unique case (r_state)
            S_TICK: begin
                cell_ctrl.age_shift_all = (r_mode == prpe_pkg::MODE_CLOCK)
                                          && (r_period != '0) && tick_fire;
            end
            S_LOOK: begin
                slot_bcast           = match_idx;
                cell_ctrl.hit_upd    = any_match;
                cell_ctrl.stamp_last = (r_mode == prpe_pkg::MODE_LRU)
                                       || (r_mode == prpe_pkg::MODE_CLOCK);
                cell_ctrl.set_top    = r_mode == prpe_pkg::MODE_CLOCK;
            end
            S_SWEEP: begin
                slot_bcast            = r_hand;
                cell_ctrl.sweep_shift = !zero_vec[r_hand];
            end
            S_WRITE: begin
                cell_ctrl.fill = 1'b1;
            end
            default: begin
            end
        endcase
    end

    for (genvar g = 0; g < FRAMES; g++) begin : g_cell
        logic [SW-1:0]    prev_stamp;
        logic [IDX_W-1:0] prev_idx;
        if (g == 0) begin : g_head
            assign prev_stamp = '0;
            assign prev_idx   = '0;
        end else begin : g_link
            assign prev_stamp = best_stamp[g-1];
            assign prev_idx   = best_idx[g-1];
        end
        prpe_cell #(
            .IDX       (g),
            .IDX_W     (IDX_W),
            .OCC_W     (OCC_W),
            .PAGE_BITS (PAGE_BITS),
            .AGE_BITS  (MAX_AGE_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (cell_ctrl),
            .i_occupancy  (r_occ),
            .i_slot       (slot_bcast),
            .i_page       (r_page),
            .i_wr         (r_wr),
            .i_now        (r_access),
            .i_age_mask   (age_mask),
            .i_age_top    (age_top),
            .i_prev_stamp (prev_stamp),
            .i_prev_idx   (prev_idx),
            .o_match      (match_vec[g]),
            .o_age_zero   (zero_vec[g]),
            .o_dirty      (dirty_vec[g]),
            .o_best_stamp (best_stamp[g]),
            .o_best_idx   (best_idx[g])
        );
    end

    assign o_in_ready        = r_state == S_IDLE;
    assign o_out_valid       = r_out_valid;
    assign o_hit             = r_out_hit;
    assign o_frame_slot      = r_out_slot;
    assign o_evicted_dirty   = r_out_evd;
    assign o_fault_total     = r_out_faults;
    assign o_writeback_total = r_out_wbs;
    assign o_dirty_resident  = r_out_dirty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= prpe_pkg::MODE_FIFO;
            r_fiu       <= prpe_pkg::FIU_W'(64);
            r_period    <= '0;
            r_agew      <= prpe_pkg::AGEW_W'(8);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                prpe_pkg::CFG_POLICY_MODE:   r_mode   <= i_cfg_wdata[1:0];
                prpe_pkg::CFG_FRAMES_IN_USE: r_fiu    <= i_cfg_wdata[prpe_pkg::FIU_W-1:0];
                prpe_pkg::CFG_AGING_PERIOD:  r_period <= i_cfg_wdata;
                prpe_pkg::CFG_AGE_WIDTH:     r_agew   <= i_cfg_wdata[prpe_pkg::AGEW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hand      <= '0;
            r_occ       <= '0;
            r_access    <= '0;
            r_tick      <= '0;
            r_faults    <= '0;
            r_wbs       <= '0;
            r_dirty_cnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // drop the result once taken, unless a new one loads this cycle
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_page  <= i_page_number;
                        r_wr    <= i_is_write;
                        r_hit   <= 1'b0;
                        r_evd   <= 1'b0;
                        r_evict <= 1'b0;
                        r_state <= S_TICK;
                    end
                end
                S_TICK: begin
                    if ((r_mode == prpe_pkg::MODE_CLOCK) && (r_period != '0)) begin
                        r_tick <= tick_fire ? '0 : tick_next;
                    end
                    r_state <= S_LOOK;
                end
                S_LOOK: begin
                    if (any_match) begin
                        r_hit  <= 1'b1;
                        r_slot <= match_idx;
                        if (r_wr && !dirty_vec[match_idx]) begin
                            r_dirty_cnt <= r_dirty_cnt + 1'b1;
                        end
                        r_state <= S_DONE;
                    end else begin
                        r_faults <= r_faults + 1'b1;
                        if (r_occ < cap) begin
                            r_slot  <= IDX_W'(r_occ);
                            r_state <= S_WRITE;
                        end else if (r_mode == prpe_pkg::MODE_CLOCK) begin
                            r_evict <= 1'b1;
                            if (OCC_W'(r_hand) >= r_occ) begin
                                r_hand <= '0;
                            end
                            r_state <= S_SWEEP;
                        end else begin
                            r_evict    <= 1'b1;
                            r_scan_cnt <= '0;
                            r_state    <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    // wait for the oldest stamp to ripple to the end of the row
                    if (r_scan_cnt == OCC_W'(FRAMES)) begin
                        r_slot  <= best_idx[FRAMES-1];
                        r_state <= S_WRITE;
                    end else begin
                        r_scan_cnt <= r_scan_cnt + 1'b1;
                    end
                end
                S_SWEEP: begin
                    if (zero_vec[r_hand]) begin
                        r_slot  <= r_hand;
                        r_state <= S_WRITE;
                    end else if (OCC_W'(r_hand) == r_occ - 1'b1) begin
                        r_hand <= '0;
                    end else begin
                        r_hand <= r_hand + 1'b1;
                    end
                end
                S_WRITE: begin
                    if (r_evict) begin
                        if (dirty_vec[r_slot]) begin
                            r_evd       <= 1'b1;
                            r_wbs       <= r_wbs + 1'b1;
                            r_dirty_cnt <= r_dirty_cnt - 1'b1 + OCC_W'(r_wr);
                        end else begin
                            r_dirty_cnt <= r_dirty_cnt + OCC_W'(r_wr);
                        end
                    end else begin
                        r_occ       <= r_occ + 1'b1;
                        r_dirty_cnt <= r_dirty_cnt + OCC_W'(r_wr);
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_hit    <= r_hit;
                        r_out_slot   <= 6'(r_slot);
                        r_out_evd    <= r_evd;
                        r_out_faults <= r_faults;
                        r_out_wbs    <= r_wbs;
                        r_out_dirty  <= 7'(r_dirty_cnt);
                        r_access     <= r_access + 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: test/tb_page_replacement_policy_engine_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for page_replacement_policy_engine_top: directed table, then
// random access streams under changing policies, checked against an in-bench frame model.
// Depends on prpe_pkg and the engine RTL.
module tb_page_replacement_policy_engine_top;

    localparam int NFR = 64;

    typedef struct packed {
        logic        hit;
        logic [5:0]  slot;
        logic        evd;
        logic [31:0] faults;
        logic [31:0] wbacks;
        logic [6:0]  dirty;
    } t_access_res;

    typedef struct packed {
        logic                            is_cfg;
        logic [prpe_pkg::CFG_ADDR_W-1:0] addr;
        logic [15:0]                     data;
        logic [19:0]                     page;
        logic                            wr;
        logic                            typed;
        t_access_res                     res;
    } t_dir_row;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [prpe_pkg::CFG_ADDR_W-1:0] i_cfg_addr;
    logic [prpe_pkg::CFG_DATA_W-1:0] i_cfg_wdata;
    logic                            i_in_valid;
    logic                            o_in_ready;
    logic [19:0]                     i_page_number;
    logic                            i_is_write;
    logic                            o_out_valid;
    logic                            i_out_ready;
    logic                            o_hit;
    logic [5:0]                      o_frame_slot;
    logic                            o_evicted_dirty;
    logic [31:0]                     o_fault_total;
    logic [31:0]                     o_writeback_total;
    logic [6:0]                      o_dirty_resident;

    page_replacement_policy_engine_top uut (.*);

    // frame table shadow
    logic [19:0] fr_tag     [NFR];
    logic        fr_dirty   [NFR];
    logic [31:0] fr_arrival [NFR];
    logic [31:0] fr_last    [NFR];
    logic [7:0]  fr_age     [NFR];
    int unsigned occ, hand, tick_cnt;
    logic [31:0] acc_cnt, fault_cnt, wb_cnt;
    int unsigned dirty_cnt;
    logic [1:0]  cfg_mode;
    logic [6:0]  cfg_fiu;
    logic [15:0] cfg_period;
    logic [3:0]  cfg_agew;

    t_access_res pending_q [$];
    int          errors;
    int          in_idle, out_idle;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("** page_replacement_policy_engine_top: FAILED **");
        $finish;
    end

    function automatic int unsigned oldest_frame(input bit by_last);
        int unsigned best;
        best = 0;
        for (int unsigned i = 1; i < occ; i++) begin
            if (by_last ? (fr_last[i] < fr_last[best]) : (fr_arrival[i] < fr_arrival[best]))
                best = i;
        end
        return best;
    endfunction

    function automatic t_access_res frame_access(input logic [19:0] page, input logic wr);
        t_access_res r;
        int unsigned w, cap, slot, n, guard;
        logic [7:0]  m, top;
        logic [1:0]  mode;
        logic [31:0] now;
        bit          hit, evd;
        mode = cfg_mode;
        now  = acc_cnt;
        w    = (cfg_agew < 1) ? 1 : ((cfg_agew > 8) ? 8 : cfg_agew);
        m    = 8'((9'd1 << w) - 1);
        top  = 8'(1 << (w - 1));
        cap  = (cfg_fiu < 1) ? 1 : ((cfg_fiu > NFR) ? NFR : cfg_fiu);
        hit  = 0;
        evd  = 0;
        slot = 0;
        if (mode == prpe_pkg::MODE_CLOCK && cfg_period != 0) begin
            tick_cnt = (tick_cnt + 1) & 16'hFFFF;
            if (tick_cnt >= cfg_period) begin
                for (int unsigned i = 0; i < occ; i++) fr_age[i] = (fr_age[i] & m) >> 1;
                tick_cnt = 0;
            end
        end
        for (int unsigned i = 0; i < occ; i++) begin
            if (!hit && fr_tag[i] == page) begin
                hit  = 1;
                slot = i;
            end
        end
        if (hit) begin
            if (wr && !fr_dirty[slot]) begin
                fr_dirty[slot] = 1'b1;
                dirty_cnt++;
            end
            if (mode == prpe_pkg::MODE_LRU || mode == prpe_pkg::MODE_CLOCK)
                fr_last[slot] = now;
            if (mode == prpe_pkg::MODE_CLOCK) fr_age[slot] = (fr_age[slot] & m) | top;
        end else begin
            fault_cnt++;
            if (occ < cap) begin
                slot = occ;
                occ++;
            end else begin
                if (mode == prpe_pkg::MODE_LRU) begin
                    slot = oldest_frame(1'b1);
                end else if (mode == prpe_pkg::MODE_CLOCK) begin
                    n = occ;
                    if (hand >= n) hand = 0;
                    guard = 10 * NFR;
                    while (guard > 0 && (fr_age[hand] & m) != 0) begin
                        guard--;
                        fr_age[hand] = (fr_age[hand] & m) >> 1;
                        hand = (hand + 1) % n;
                    end
                    slot = hand;
                end else begin
                    slot = oldest_frame(1'b0);
                end
                if (fr_dirty[slot]) begin
                    evd = 1;
                    wb_cnt++;
                    dirty_cnt--;
                end
            end
            fr_tag[slot]     = page;
            fr_dirty[slot]   = wr;
            if (wr) dirty_cnt++;
            fr_arrival[slot] = now;
            fr_last[slot]    = now;
            fr_age[slot]     = top;
        end
        acc_cnt++;
        r.hit    = hit;
        r.slot   = 6'(slot);
        r.evd    = evd;
        r.faults = fault_cnt;
        r.wbacks = wb_cnt;
        r.dirty  = 7'(dirty_cnt);
        return r;
    endfunction

    // hold until the engine has drained every transaction
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [prpe_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [15:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
        case (addr)
            prpe_pkg::CFG_POLICY_MODE:   cfg_mode   = data[1:0];
            prpe_pkg::CFG_FRAMES_IN_USE: cfg_fiu    = data[6:0];
            prpe_pkg::CFG_AGING_PERIOD:  cfg_period = data;
            prpe_pkg::CFG_AGE_WIDTH:     cfg_agew   = data[3:0];
            default: ;
        endcase
    endtask

    task automatic send_access(input logic [19:0] page, input logic wr, input bit typed,
                               input t_access_res typed_res);
        t_access_res r;
        while ($urandom_range(99) < in_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_page_number <= page;
        i_is_write    <= wr;
        do @(posedge i_clk); while (!o_in_ready);
        r = frame_access(page, wr);
        pending_q.push_back(typed ? typed_res : r);
    endtask

    task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] a);
        if (e !== a) begin
            $error("%s: expected %0h, got %0h", name, e, a);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_access_res e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_q.size() == 0) begin
                $error("result transaction with nothing expected");
                errors++;
            end else begin
                e = pending_q.pop_front();
                check_field("hit", e.hit, o_hit);
                check_field("frame_slot", e.slot, o_frame_slot);
                check_field("evicted_dirty", e.evd, o_evicted_dirty);
                check_field("fault_total", e.faults, o_fault_total);
                check_field("writeback_total", e.wbacks, o_writeback_total);
                check_field("dirty_resident", e.dirty, o_dirty_resident);
            end
        end
        i_out_ready <= i_rst_n && ($urandom_range(99) >= out_idle);
    end

    function automatic t_dir_row cfg_row(input logic [prpe_pkg::CFG_ADDR_W-1:0] a,
                                         input logic [15:0] d);
        return '{1'b1, a, d, 20'd0, 1'b0, 1'b0, '0};
    endfunction

    function automatic t_dir_row acc_row(input logic [19:0] p, input logic wr);
        return '{1'b0, '0, 16'd0, p, wr, 1'b0, '0};
    endfunction

    function automatic t_dir_row chk_row(input logic [19:0] p, input logic wr,
                                         input t_access_res r);
        return '{1'b0, '0, 16'd0, p, wr, 1'b1, r};
    endfunction

    initial begin
        t_dir_row    dir_tab [$];
        t_access_res none;
        int unsigned span, cap;
        logic [19:0] base, page;
        int          guard;

        errors = 0;
        none = '0;
        in_idle = 22;
        out_idle = 86;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_addr = '0;
        i_cfg_wdata = '0;
        i_in_valid = 1'b0;
        i_page_number = '0;
        i_is_write = 1'b0;
        i_out_ready = 1'b0;
        for (int i = 0; i < NFR; i++) begin
            fr_tag[i] = '0; fr_dirty[i] = 0; fr_arrival[i] = '0; fr_last[i] = '0; fr_age[i] = '0;
        end
        occ = 0; hand = 0; tick_cnt = 0; acc_cnt = 0; fault_cnt = 0; wb_cnt = 0; dirty_cnt = 0;
        cfg_mode = prpe_pkg::MODE_FIFO; cfg_fiu = 7'd64; cfg_period = 16'd0; cfg_agew = 4'd8;

        dir_tab = '{
            chk_row(20'h00000, 1'b0, '{1'b0, 6'd0, 1'b0, 32'd1, 32'd0, 7'd0}),
            chk_row(20'hFFFFF, 1'b1, '{1'b0, 6'd1, 1'b0, 32'd2, 32'd0, 7'd1}),
            chk_row(20'h00000, 1'b1, '{1'b1, 6'd0, 1'b0, 32'd2, 32'd0, 7'd2}),
            cfg_row(prpe_pkg::CFG_FRAMES_IN_USE, 16'd2),
            chk_row(20'h00005, 1'b0, '{1'b0, 6'd0, 1'b1, 32'd3, 32'd1, 7'd1}),
            chk_row(20'h00006, 1'b0, '{1'b0, 6'd1, 1'b1, 32'd4, 32'd2, 7'd0}),
            cfg_row(prpe_pkg::CFG_POLICY_MODE, 16'(prpe_pkg::MODE_LRU)),
            acc_row(20'h00005, 1'b1),
            acc_row(20'h00007, 1'b0),
            cfg_row(prpe_pkg::CFG_POLICY_MODE, 16'(prpe_pkg::MODE_CLOCK)),
            cfg_row(prpe_pkg::CFG_AGING_PERIOD, 16'd1),
            cfg_row(prpe_pkg::CFG_AGE_WIDTH, 16'd0),
            acc_row(20'h00007, 1'b0),
            acc_row(20'h00008, 1'b1),
            acc_row(20'h00009, 1'b0),
            acc_row(20'h00008, 1'b1),
            cfg_row(prpe_pkg::CFG_AGE_WIDTH, 16'd15),
            cfg_row(prpe_pkg::CFG_AGING_PERIOD, 16'hFFFF),
            cfg_row(prpe_pkg::CFG_FRAMES_IN_USE, 16'd0),
            acc_row(20'h00001, 1'b0),
            acc_row(20'h00002, 1'b1),
            cfg_row(prpe_pkg::CFG_POLICY_MODE, 16'd3),
            cfg_row(prpe_pkg::CFG_FRAMES_IN_USE, 16'd127),
            acc_row(20'h00003, 1'b1),
            acc_row(20'hFFFFF, 1'b0),
            acc_row(20'hAAAAA, 1'b1),
            acc_row(20'h55555, 1'b0)
        };

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[k]) begin
            if (dir_tab[k].is_cfg) begin
                wait_drained();
                write_reg(dir_tab[k].addr, dir_tab[k].data);
            end else begin
                send_access(dir_tab[k].page, dir_tab[k].wr, dir_tab[k].typed, dir_tab[k].res);
            end
        end

        for (int ph = 0; ph < 8; ph++) begin
            wait_drained();
            in_idle  = (ph < 3) ? 22 : ((ph < 6) ? 86 : 0);
            out_idle = (ph < 3) ? 86 : ((ph < 6) ? 22 : 0);
            write_reg(prpe_pkg::CFG_POLICY_MODE, 16'($urandom_range(3)));
            case ($urandom_range(5))
                0: write_reg(prpe_pkg::CFG_FRAMES_IN_USE, 16'd1);
                1: write_reg(prpe_pkg::CFG_FRAMES_IN_USE, 16'd64);
                2: write_reg(prpe_pkg::CFG_FRAMES_IN_USE, 16'($urandom_range(127)));
                default: write_reg(prpe_pkg::CFG_FRAMES_IN_USE, 16'($urandom_range(2, 12)));
            endcase
            case ($urandom_range(4))
                0: write_reg(prpe_pkg::CFG_AGING_PERIOD, 16'd0);
                1: write_reg(prpe_pkg::CFG_AGING_PERIOD, 16'hFFFF);
                2: write_reg(prpe_pkg::CFG_AGING_PERIOD, 16'($urandom));
                default: write_reg(prpe_pkg::CFG_AGING_PERIOD, 16'($urandom_range(1, 6)));
            endcase
            write_reg(prpe_pkg::CFG_AGE_WIDTH, 16'($urandom_range(15)));
            cap  = (cfg_fiu < 1) ? 1 : ((cfg_fiu > NFR) ? NFR : cfg_fiu);
            span = cap + cap / 2 + 2;
            base = 20'($urandom);
            for (int n = 0; n < 125; n++) begin
                // drain everything once mid-run before pushing on
                if (ph == 4 && n == 60) wait_drained();
                if ($urandom_range(99) < 80) page = base ^ 20'($urandom_range(span));
                else page = 20'($urandom);
                send_access(page, 1'($urandom_range(1)), 1'b0, none);
            end
        end

        i_in_valid <= 1'b0;
        guard = 0;
        while (pending_q.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (50) @(posedge i_clk);
        if (pending_q.size() != 0) begin
            $error("%0d results never arrived", pending_q.size());
            errors++;
        end
        if (errors == 0) begin
            $display("** page_replacement_policy_engine_top: PASSED **");
        end else begin
            $display("** page_replacement_policy_engine_top: FAILED **");
        end
        $finish;
    end

endmodule
